// File: rtl/smt_pkg.sv
// Shared types and codes for the set membership table.
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

    // Request kind codes as they arrive on the request port
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_REMOVE   = 2'd1;
    localparam logic [1:0] KIND_CONTAINS = 2'd2;
    localparam logic [1:0] KIND_POP      = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Operation as classified by the front end
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_CONTAINS,
        OP_POP
    } op_t;

    // Request payload
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] item_value;
    } req_t;

    // Result payload
    typedef struct packed {
        logic               found;
        logic signed [31:0] popped_value;
        logic [4:0]         entry_count;
        logic [1:0]         status;
    } rsp_t;

    // Queue entry between front end and execution engine
    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } q_item_t;

    // Execution engine states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN_RD,
        BK_SCAN_CMP,
        BK_SHIFT_RD,
        BK_SHIFT_WR,
        BK_POP_DONE
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/smt_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none

module smt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire smt_pkg::req_t    req,
    output logic                  busy,
    output logic                  q_valid,
    output smt_pkg::q_item_t      q_item,
    input  wire logic             q_pop
);

    smt_pkg::q_item_t slot_reg [2];
    logic [1:0]       fill_reg, fill_next;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic             push;
    smt_pkg::q_item_t new_item;

    // Classify the incoming request
    always_comb
    begin
        new_item.value = req.item_value;
        case (req.kind)
            smt_pkg::KIND_INSERT:   new_item.op = smt_pkg::OP_INSERT;
            smt_pkg::KIND_REMOVE:   new_item.op = smt_pkg::OP_REMOVE;
            smt_pkg::KIND_CONTAINS: new_item.op = smt_pkg::OP_CONTAINS;
            smt_pkg::KIND_POP:      new_item.op = smt_pkg::OP_POP;
            default:                new_item.op = smt_pkg::OP_CONTAINS;
        endcase
    end

    // Two-entry queue control
    assign busy    = (fill_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, q_pop && q_valid})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/smt_back.sv
// Execution engine: entry store, scan, shift-down and pop sequencer.
`timescale 1ns / 1ps
`default_nettype none

module smt_back #(
    parameter int CAPACITY = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire smt_pkg::q_item_t  q_item,
    output logic                   q_pop,
    output logic                   done,
    output smt_pkg::rsp_t          rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    smt_pkg::back_state_t state_reg, state_next;
    smt_pkg::op_t         op_reg, op_next;
    logic signed [31:0]   val_reg, val_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 done_reg, done_next;
    smt_pkg::rsp_t        rsp_reg, rsp_next;

    // Entry store
    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;

    logic          hit;
    logic [CW:0]   idx_p1, idx_p2, count_x;
    logic [CW-1:0] count_m1;

    assign hit      = (rdata_reg == val_reg);
    assign idx_p1   = {1'b0, idx_reg} + 1'b1;
    assign idx_p2   = {1'b0, idx_reg} + 2'd2;
    assign count_x  = {1'b0, count_reg};
    assign count_m1 = count_reg - 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smt_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == smt_pkg::OP_POP)
                    begin
                        state_next = (count_reg == '0) ? smt_pkg::BK_IDLE
                                                       : smt_pkg::BK_POP_DONE;
                    end
                    else
                    begin
                        state_next = smt_pkg::BK_SCAN_RD;
                    end
                end
            end
            smt_pkg::BK_SCAN_RD:
            begin
                state_next = (idx_reg == count_reg) ? smt_pkg::BK_IDLE
                                                    : smt_pkg::BK_SCAN_CMP;
            end
            smt_pkg::BK_SCAN_CMP:
            begin
                if (hit)
                begin
                    state_next = (op_reg == smt_pkg::OP_REMOVE && idx_p1 < count_x)
                                 ? smt_pkg::BK_SHIFT_RD : smt_pkg::BK_IDLE;
                end
                else
                begin
                    state_next = smt_pkg::BK_SCAN_RD;
                end
            end
            smt_pkg::BK_SHIFT_RD:
            begin
                state_next = smt_pkg::BK_SHIFT_WR;
            end
            smt_pkg::BK_SHIFT_WR:
            begin
                state_next = (idx_p2 < count_x) ? smt_pkg::BK_SHIFT_RD
                                                : smt_pkg::BK_IDLE;
            end
            smt_pkg::BK_POP_DONE:
            begin
                state_next = smt_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = smt_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath, store access and result
    always_comb
    begin
        op_next    = op_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = rdata_reg;
        case (state_reg)
            smt_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    op_next  = q_item.op;
                    val_next = q_item.value;
                    idx_next = '0;
                    if (q_item.op == smt_pkg::OP_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next             = 1'b1;
                            rsp_next.found        = 1'b0;
                            rsp_next.popped_value = '0;
                            rsp_next.status       = smt_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = count_m1[AW-1:0];
                        end
                    end
                end
            end
            smt_pkg::BK_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // value absent
                    done_next             = 1'b1;
                    rsp_next.found        = 1'b0;
                    rsp_next.popped_value = '0;
                    rsp_next.status       = smt_pkg::ST_OK;
                    if (op_reg == smt_pkg::OP_INSERT)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            rsp_next.status = smt_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = val_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            smt_pkg::BK_SCAN_CMP:
            begin
                if (hit)
                begin
                    if (!(op_reg == smt_pkg::OP_REMOVE && idx_p1 < count_x))
                    begin
                        done_next             = 1'b1;
                        rsp_next.found        = 1'b1;
                        rsp_next.popped_value = '0;
                        rsp_next.status       = smt_pkg::ST_OK;
                        if (op_reg == smt_pkg::OP_REMOVE)
                        begin
                            count_next = count_m1;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_p1[CW-1:0];
                end
            end
            smt_pkg::BK_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[AW-1:0];
            end
            smt_pkg::BK_SHIFT_WR:
            begin
                // move the next entry down one slot
                wr_en    = 1'b1;
                idx_next = idx_p1[CW-1:0];
                if (!(idx_p2 < count_x))
                begin
                    count_next            = count_m1;
                    done_next             = 1'b1;
                    rsp_next.found        = 1'b1;
                    rsp_next.popped_value = '0;
                    rsp_next.status       = smt_pkg::ST_OK;
                end
            end
            smt_pkg::BK_POP_DONE:
            begin
                count_next            = count_m1;
                done_next             = 1'b1;
                rsp_next.found        = 1'b0;
                rsp_next.popped_value = rdata_reg;
                rsp_next.status       = smt_pkg::ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        if (done_next)
        begin
            rsp_next.entry_count = 5'(count_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smt_pkg::BK_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/set_membership_table.sv
// Top level of the set membership table.
//
// A store of up to CAPACITY distinct 32-bit signed values with insert,
// remove, contains and remove-one (pop of the highest used slot).
// Request channel: start with req; a request is taken at a clock edge where
// start is high and busy is low. A two-entry queue sits behind the port, so
// busy only rises when two requests are waiting for the engine.
// Result channel: done is high for exactly one cycle with rsp; the receiver
// cannot stall it. Every request gives exactly one result, in order.
// Engine steps, from acceptance to done, with n entries held:
//   contains / insert: a read and a compare per entry scanned, up to a hit
//     or, when the value is absent, past all n entries
//   remove: scan as above plus a read and a write per entry shifted down
//   remove-one: a read of the highest used slot, none on an empty store
// The split into steps comes from the entry store's registered read: each
// scanned entry costs a read and a compare, each shifted entry a read and a write.
// Requests are worked one at a time by the engine, in order of acceptance.
// Reset clears the entry count and the queue; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module set_membership_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire smt_pkg::req_t  req,
    output logic                busy,
    output logic                done,
    output smt_pkg::rsp_t       rsp
);

    logic             q_valid;
    logic             q_pop;
    smt_pkg::q_item_t q_item;

    smt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    smt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .done    (done),
        .rsp     (rsp)
    );

    // A dropped insert only happens on a full store and never on a hit
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == smt_pkg::ST_FULL
        |-> !rsp.found && rsp.entry_count == 5'(CAPACITY))
        else $error("full status without a full store");

    // Popping an empty store leaves it empty and returns zero
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == smt_pkg::ST_EMPTY
        |-> rsp.entry_count == 5'd0 && rsp.popped_value == 32'sd0 && !rsp.found)
        else $error("empty status with entries held");

    // A hit always completes with ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.found |-> rsp.status == smt_pkg::ST_OK)
        else $error("found result with error status");

endmodule

`default_nettype wire
